@@ hdl/mhc_pkg.sv @@
// Shared types, constants and the CORDIC angle table function for the
// magnetometer heading calculator. No dependencies.
package mhc_pkg;

    localparam int CORDIC_STEPS_DEF    = 20;
    localparam int ANGLE_FRAC_BITS_DEF = 16;

    // Datapath width of the CORDIC vector (corrected field is below 2^43)
    localparam int XW          = 48;
    localparam int QDEPTH      = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 26;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_SCALE_X  = 3'd2,
        REG_SCALE_Y  = 3'd3,
        REG_DECL     = 3'd4
    } t_reg_idx;

    // Quadrant class from the front: no pre-rotation, rotated with +180 or
    // -180 base, or both components zero.
    typedef enum logic [1:0] {
        Q_NONE     = 2'd0,
        Q_POS_HALF = 2'd1,
        Q_NEG_HALF = 2'd2,
        Q_ZERO     = 2'd3
    } t_quad;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
    } t_in;

    typedef struct packed {
        logic [8:0] azimuth_deg;
        logic [3:0] bearing_index;
    } t_out;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        t_quad                quad;
    } t_job;

    // Restoring division, used only at elaboration for the angle table
    function automatic longint unsigned udivmod(input longint unsigned a,
                                                input longint unsigned b,
                                                input bit want_rem);
        longint unsigned q;
        longint unsigned r;
        q = 0;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            r = {r[62:0], a[k]};
            if (r >= b) begin
                r = r - b;
                q[k] = 1'b1;
            end
        end
        return want_rem ? r : q;
    endfunction

    // atan(1/m) in Q48 radians by its series
    function automatic longint unsigned atan_recip(input longint unsigned m);
        longint unsigned p;
        longint unsigned m2;
        longint unsigned sum;
        longint unsigned k;
        longint unsigned t;
        bit              neg;
        p   = udivmod(64'd1 << 48, m, 1'b0);
        m2  = m * m;
        sum = 0;
        k   = 0;
        neg = 1'b0;
        while (p != 0) begin
            t   = udivmod(p, 2 * k + 1, 1'b0);
            sum = neg ? sum - t : sum + t;
            p   = udivmod(p, m2, 1'b0);
            k   = k + 1;
            neg = !neg;
        end
        return sum;
    endfunction

    // atan(2^-i) in units of 2^-frac degree, rounded half up
    function automatic longint atan_entry(input int i, input int frac);
        longint unsigned q;
        longint unsigned num;
        longint unsigned quo;
        longint unsigned rem;
        if (i == 0)
            return longint'(45) << frac;
        q   = 4 * atan_recip(5) - atan_recip(239);
        num = atan_recip(64'd1 << i) * 45;
        quo = udivmod(num, q, 1'b0);
        rem = udivmod(num, q, 1'b1);
        for (int b = 0; b <= frac; b++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= q) begin
                rem = rem - q;
                quo = quo | 64'd1;
            end
        end
        return longint'((quo + 1) >> 1);
    endfunction

endpackage

@@ hdl/mhc_front.sv @@
// Front end: applies hard- and soft-iron correction and classifies the
// quadrant of each sample. Depends on mhc_pkg.
module mhc_front import mhc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in_data,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic [25:0]        i_scale_x,
    input  logic [25:0]        i_scale_y,
    input  logic               i_q_full,
    output logic               o_push,
    output t_job               o_job
);

    logic                 r_f1_valid;
    logic                 r_f2_valid;
    logic signed [XW-1:0] r_cx;
    logic signed [XW-1:0] r_cy;
    t_job                 r_job;
    logic                 fen;
    logic signed [16:0]   dx;
    logic signed [16:0]   dy;
    logic signed [43:0]   px;
    logic signed [43:0]   py;
    t_job                 n_job;

    assign fen        = !r_f2_valid || !i_q_full;
    assign o_in_stall = !fen;
    assign o_push     = r_f2_valid && !i_q_full;
    assign o_job      = r_job;

    always_comb begin
        dx = {i_in_data.raw_x[15], i_in_data.raw_x} - {i_offset_x[15], i_offset_x};
        dy = {i_in_data.raw_y[15], i_in_data.raw_y} - {i_offset_y[15], i_offset_y};
        px = dx * $signed({1'b0, i_scale_x});
        py = dy * $signed({1'b0, i_scale_y});
    end

    // x = -cy, y = cx; fold the left half plane onto the right
    always_comb begin
        n_job.x    = -r_cy;
        n_job.y    = r_cx;
        n_job.quad = Q_NONE;
        if (r_cx == '0 && r_cy == '0) begin
            n_job.quad = Q_ZERO;
        end else if (r_cy > 0) begin
            n_job.x    = r_cy;
            n_job.y    = -r_cx;
            n_job.quad = (r_cx >= 0) ? Q_POS_HALF : Q_NEG_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else if (fen) begin
            r_f1_valid <= i_in_valid;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fen) begin
            r_cx  <= {{(XW-44){px[43]}}, px};
            r_cy  <= {{(XW-44){py[43]}}, py};
            r_job <= n_job;
        end
    end

endmodule

@@ hdl/mhc_queue.sv @@
// Short queue of classified jobs between front and back end.
// Depends on mhc_pkg.
module mhc_queue import mhc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PW = $clog2(QDEPTH);

    t_job          r_mem [QDEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push)
                r_wr <= r_wr + 1'b1;
            if (i_pop)
                r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)
                r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop)
                r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_job;
    end

endmodule

@@ hdl/mhc_back.sv @@
// Back end: pipelined vectoring CORDIC, declination, remap and degree/sector
// conversion. Depends on mhc_pkg (types and angle table function).
module mhc_back import mhc_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic signed [14:0] i_decl,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out_data
);

    localparam int N  = CORDIC_STEPS;
    localparam int F  = ANGLE_FRAC_BITS;
    localparam int ZW = F + 10;
    localparam int HW = F + 17;
    localparam int UW = F + 15;
    localparam logic signed [ZW-1:0] HALF  = ZW'(longint'(180) << F);
    localparam logic signed [HW-1:0] FULL  = HW'(longint'(21600) << F);
    localparam logic signed [HW-1:0] FULL2 = HW'(longint'(43200) << F);
    localparam logic [UW-1:0] FULL_U = UW'(longint'(21600) << F);
    localparam logic [UW-1:0] REMAP  = UW'(longint'(32400) << F);
    localparam logic [15:0] RECIP60 = 16'd34953;  // ceil(2^21/60)
    localparam logic [11:0] RECIP45 = 12'd2914;   // 2*ceil(2^16/45)

    logic                 ben;
    logic                 r_v [N+1];
    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    t_quad                r_q [N+1];

    logic          r_p1_v, r_p2_v, r_p3_v, r_p4_v;
    logic [UW-1:0] r_hh;
    logic [14:0]   r_deg;
    logic [8:0]    r_az;
    t_out          r_out;

    logic signed [ZW-1:0] h;
    logic signed [HW-1:0] hs;
    logic signed [HW-1:0] sum;
    logic signed [HW-1:0] wrapped;
    logic [UW-1:0]        h2;
    logic [30:0]          p60;
    logic [20:0]          p45;

    assign ben         = !r_p4_v || !i_out_stall;
    assign o_pop       = ben && !i_q_empty;
    assign o_out_valid = r_p4_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_x[0] <= i_job.x;
            r_y[0] <= i_job.y;
            r_z[0] <= '0;
            r_q[0] <= i_job.quad;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_step
        localparam logic signed [ZW-1:0] TAB = ZW'(atan_entry(i, F));
        always_ff @(posedge i_clk) begin
            if (ben) begin
                if (r_y[i] > 0) begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + TAB;
                end else begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - TAB;
                end
                r_q[i+1] <= r_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= N; k++)
                r_v[k] <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (ben) begin
            r_v[0] <= !i_q_empty;
            for (int k = 0; k < N; k++)
                r_v[k+1] <= r_v[k];
            r_p1_v <= r_v[N];
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    // Add base angle and declination, then true modulo 360 degrees
    always_comb begin
        case (r_q[N])
            Q_ZERO:     h = HALF;
            Q_POS_HALF: h = r_z[N] + HALF;
            Q_NEG_HALF: h = r_z[N] - HALF;
            default:    h = r_z[N];
        endcase
        hs  = {{(HW-ZW){h[ZW-1]}}, h};
        sum = (hs <<< 6) - (hs <<< 2) + {{2{i_decl[14]}}, i_decl, {F{1'b0}}};
        if (sum >= FULL)
            wrapped = sum - FULL;
        else if (sum < -FULL)
            wrapped = sum + FULL2;
        else if (sum < 0)
            wrapped = sum + FULL;
        else
            wrapped = sum;
    end

    always_comb begin
        h2 = REMAP - r_hh;
        if (h2 >= FULL_U)
            h2 = h2 - FULL_U;
        p60 = r_deg * RECIP60;
        p45 = r_az * RECIP45;
    end

    always_ff @(posedge i_clk) begin
        if (ben) begin
            r_hh  <= wrapped[UW-1:0];
            r_deg <= h2[UW-1:F];
            r_az  <= p60[29:21];
            r_out.azimuth_deg   <= r_az;
            r_out.bearing_index <= p45[19:16];
        end
    end

endmodule

@@ hdl/magnetometer_heading_calc.sv @@
// Compass heading from one X/Y magnetometer sample per transaction.
// Accepts a sample every cycle while o_in_stall is low. Each sample passes two
// front-end registers (correction multiply, quadrant fold), the queue entry, the
// CORDIC input register and one register per CORDIC step, then four registers
// for declination, remap and the degree and sector conversions. A four-entry queue
// separates the front and back ends so that each stalls independently.
// Configuration registers are always ready and should be written only while
// the block is idle.
// Depends on mhc_pkg, mhc_front, mhc_queue, mhc_back.
module magnetometer_heading_calc import mhc_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic signed [15:0] r_offset_x;
    logic signed [15:0] r_offset_y;
    logic [25:0]        r_scale_x;
    logic [25:0]        r_scale_y;
    logic signed [14:0] r_decl;

    logic q_full, q_empty, push, pop;
    t_job front_job, q_job;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_scale_x  <= 26'd1 << 24;
            r_scale_y  <= 26'd1 << 24;
            r_decl     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_OFFSET_X: r_offset_x <= i_cfg_data[15:0];
                REG_OFFSET_Y: r_offset_y <= i_cfg_data[15:0];
                REG_SCALE_X:  r_scale_x  <= i_cfg_data[25:0];
                REG_SCALE_Y:  r_scale_y  <= i_cfg_data[25:0];
                REG_DECL:     r_decl     <= i_cfg_data[14:0];
                default:      ;
            endcase
        end
    end

    mhc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_offset_x (r_offset_x),
        .i_offset_y (r_offset_y),
        .i_scale_x  (r_scale_x),
        .i_scale_y  (r_scale_y),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    mhc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    mhc_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_job       (q_job),
        .o_pop       (pop),
        .i_decl      (r_decl),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule
